// ===== sv/ldr_pkg.sv =====
// ldr_pkg: shared types, constants and tables for the linked downward reducer.
// Used by every module of the block; depends on nothing.
package ldr_pkg;

   localparam int CHANNELS_DEF    = 2;
   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int ADDR_W          = 5;

   localparam logic [23:0] UNITY_GAIN     = 24'd4194304;
   localparam logic [15:0] FULL_LINK      = 16'd65470;
   localparam logic [31:0] DB_PER_OCTAVE  = 32'd394566;
   localparam logic [31:0] OCTAVES_PER_DB = 32'd10885;
   localparam logic [31:0] Q30_ONE        = 32'h4000_0000;

   typedef enum logic [2:0] {
      REG_ATTACK,
      REG_RELEASE,
      REG_GAIN,
      REG_THRESHOLD,
      REG_MAX_DB,
      REG_STATIC,
      REG_LINK,
      REG_SLOPE
   } reg_index_type;

   typedef struct packed {
      logic signed [23:0] sample_left;
      logic signed [23:0] sample_right;
      logic [15:0]        gate_amount;
      logic               block_start;
   } req_type;

   typedef struct packed {
      logic signed [23:0] delta_left;
      logic signed [23:0] delta_right;
      logic [14:0]        applied_db;
      logic [14:0]        peak_db;
   } rsp_type;

   typedef struct packed {
      logic [23:0] attack_coeff;
      logic [23:0] release_coeff;
      logic [23:0] gain_coeff;
      logic [22:0] threshold_level;
      logic [14:0] max_reduction_db;
      logic [23:0] static_gain;
      logic [15:0] stereo_link;
      logic [15:0] reduction_slope;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      attack_coeff:     24'd16609443,
      release_coeff:    24'd16760000,
      gain_coeff:       24'd16700000,
      threshold_level:  23'd838861,
      max_reduction_db: 15'd0,
      static_gain:      24'd4194304,
      stereo_link:      16'd65535,
      reduction_slope:  16'd32768
   };

   // classified item as it waits between front and back
   typedef struct packed {
      logic signed [23:0] sample_left;
      logic signed [23:0] sample_right;
      logic [16:0]        openness;
      logic               block_start;
      logic               bypass;
      logic               full_link;
      logic [23:0]        det_left;
      logic [23:0]        det_right;
   } queue_type;

   function automatic logic [23:0] abs24(input logic signed [23:0] s);
      logic [23:0] u;
      u = s;
      return s[23] ? (~u + 24'd1) : u;
   endfunction

   // 2^(-2^-(k+1)) in Q1.30
   function automatic logic [31:0] half_step(input logic [3:0] k);
      logic [31:0] v;
      case (k)
         4'd0:    v = 32'd759250125;
         4'd1:    v = 32'd902905651;
         4'd2:    v = 32'd984625594;
         4'd3:    v = 32'd1028218693;
         4'd4:    v = 32'd1050733751;
         4'd5:    v = 32'd1062175491;
         4'd6:    v = 32'd1067942999;
         4'd7:    v = 32'd1070838486;
         4'd8:    v = 32'd1072289173;
         4'd9:    v = 32'd1073015253;
         4'd10:   v = 32'd1073378477;
         4'd11:   v = 32'd1073560135;
         4'd12:   v = 32'd1073650976;
         4'd13:   v = 32'd1073696399;
         4'd14:   v = 32'd1073719111;
         4'd15:   v = 32'd1073730468;
         default: v = Q30_ONE;
      endcase
      return v;
   endfunction

endpackage

// ===== sv/ldr_queue.sv =====
// ldr_queue: short FIFO of classified items between front and back.
// Depends on ldr_pkg (queue_type).
module ldr_queue #(
   parameter int DEPTH = ldr_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ldr_pkg::queue_type  push_data,
   input  logic                pop,
   output ldr_pkg::queue_type  pop_data,
   output logic                full,
   output logic                empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   ldr_pkg::queue_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ff, rd_ff;
   logic [CW-1:0] count_ff;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            slot_ff[wr_ff] <= push_data;
            wr_ff <= (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
         end
         if (pop) begin
            rd_ff <= (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

endmodule

// ===== sv/ldr_front.sv =====
// ldr_front: accepts items, forms the linked detector levels and classifies
// bypass and full link. Depends on ldr_pkg.
module ldr_front #(
   parameter int CHANNELS = ldr_pkg::CHANNELS_DEF
) (
   input  logic                req_valid,
   output logic                req_ready,
   input  ldr_pkg::req_type    req_data,
   input  ldr_pkg::cfg_type    cfg,
   input  logic                q_full,
   output logic                q_push,
   output ldr_pkg::queue_type  q_data
);

   localparam bit STEREO = (CHANNELS >= 2);

   logic [23:0] mag_l, mag_r, loud, det_l, det_r;
   logic [39:0] link_l, link_r;
   logic        full;

   always_comb begin
      mag_l  = ldr_pkg::abs24(req_data.sample_left);
      mag_r  = ldr_pkg::abs24(req_data.sample_right);
      loud   = (STEREO && (mag_r > mag_l)) ? mag_r : mag_l;
      full   = !STEREO || (cfg.stereo_link >= ldr_pkg::FULL_LINK);
      link_l = 40'(cfg.stereo_link) * 40'(loud - mag_l) + 40'd32768;
      link_r = 40'(cfg.stereo_link) * 40'(loud - mag_r) + 40'd32768;
      det_l  = mag_l + link_l[39:16];
      det_r  = mag_r + link_r[39:16];

      q_data.sample_left  = req_data.sample_left;
      q_data.sample_right = req_data.sample_right;
      q_data.openness     = 17'h10000 - 17'(req_data.gate_amount);
      q_data.block_start  = req_data.block_start;
      q_data.bypass       = (cfg.max_reduction_db == '0) &&
                            (cfg.static_gain == ldr_pkg::UNITY_GAIN);
      q_data.full_link    = full;
      // full link: one detector, the louder magnitude
      q_data.det_left     = full ? loud : det_l;
      q_data.det_right    = det_r;
   end

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

endmodule

// ===== sv/ldr_back.sv =====
// ldr_back: sequencer around one shared 32x32 multiplier; envelope, log2,
// reduction, exp gain, smoothing and deltas. Depends on ldr_pkg.
module ldr_back #(
   parameter int CHANNELS = ldr_pkg::CHANNELS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  ldr_pkg::cfg_type    cfg,
   input  logic                q_empty,
   output logic                q_pop,
   input  ldr_pkg::queue_type  q_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ldr_pkg::rsp_type    rsp_data
);

   typedef enum logic [4:0] {
      S_IDLE, S_LOG_START, S_LOG_SQ, S_LOG_UPD, S_CH_START, S_ENV_UPD,
      S_RED_OVER, S_RED_SLOPE, S_RED_OPEN, S_GAIN_E, S_ATT_MUL, S_ATT_UPD,
      S_ATT_SHIFT, S_TGT, S_GBLEND, S_GAIN_UPD, S_DELTA_MUL, S_DELTA_RES, S_OUT
   } state_type;

   state_type          state_ff;
   ldr_pkg::queue_type item_ff;
   logic               ch_ff;
   logic [31:0]        mul_a_ff, mul_b_ff;
   logic [23:0]        log_x_ff;
   logic [4:0]         log_top_ff;
   logic [30:0]        log_m_ff;
   logic [15:0]        log_frac_ff;
   logic               env_ret_ff;
   logic [20:0]        lthr_ff;
   logic [3:0]         step_ff;
   logic [23:0]        level_ff, target_ff;
   logic               up_ff, neg_ff;
   logic [14:0]        applied_ff, app_max_ff, peak_ff;
   logic [15:0]        whole_ff, frac_e_ff;
   logic [31:0]        att_ff;
   logic [23:0]        env_ff   [CHANNELS];
   logic [23:0]        gain_ff  [CHANNELS];
   logic [23:0]        delta_ff [CHANNELS];
   logic               rsp_valid_ff;
   ldr_pkg::rsp_type   rsp_data_ff;

   logic [63:0] prod, rnd24, rnd30, rnd22;
   logic [23:0] env_cur, gain_cur, level_cur, d24, env_new, gain_new, delta_right_cur;
   logic signed [23:0] sample_cur;
   logic [22:0] thr_eff;
   logic [4:0]  top;
   logic [30:0] m0, m_next;
   logic [31:0] sq_t, att_s;
   logic [15:0] frac_next;
   logic [20:0] lval;
   logic [47:0] scaled;
   logic [14:0] clamp;
   logic [41:0] dm;
   logic [23:0] gmag, delta_val;
   logic        gneg;
   logic [14:0] peak_new;

   always_comb begin
      prod  = 64'(mul_a_ff) * 64'(mul_b_ff);
      rnd24 = prod + 64'd8388608;
      rnd30 = prod + 64'd536870912;
      rnd22 = prod + 64'd2097152;
      d24   = rnd24[47:24];

      env_cur  = env_ff[0];
      gain_cur = gain_ff[0];
      delta_right_cur = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         if (ch_ff == 1'(c)) begin
            env_cur  = env_ff[c];
            gain_cur = gain_ff[c];
         end
         if (c == 1) delta_right_cur = delta_ff[c];
      end
      level_cur  = (ch_ff && !item_ff.full_link) ? item_ff.det_right : item_ff.det_left;
      sample_cur = ch_ff ? item_ff.sample_right : item_ff.sample_left;
      thr_eff    = (cfg.threshold_level == '0) ? 23'd1 : cfg.threshold_level;

      top = '0;
      for (int i = 0; i < 24; i++) begin
         if (log_x_ff[i]) top = 5'(i);
      end
      m0        = 31'(log_x_ff) << (5'd30 - top);
      sq_t      = prod[61:30];
      m_next    = sq_t[31] ? sq_t[31:1] : sq_t[30:0];
      frac_next = log_frac_ff | (16'(sq_t[31]) << step_ff);
      lval      = {log_top_ff, frac_next};

      env_new  = up_ff ? level_ff + d24 : level_ff - d24;
      gain_new = up_ff ? target_ff + d24 : target_ff - d24;

      scaled = prod[63:16];
      clamp  = (scaled > 48'(cfg.max_reduction_db)) ? cfg.max_reduction_db : scaled[14:0];
      att_s  = (whole_ff >= 16'd31) ? '0 : (att_ff >> whole_ff[4:0]);

      gneg = gain_cur < ldr_pkg::UNITY_GAIN;
      gmag = gneg ? ldr_pkg::UNITY_GAIN - gain_cur : gain_cur - ldr_pkg::UNITY_GAIN;
      dm   = rnd22[63:22];
      if (neg_ff) begin
         delta_val = (dm > 42'd8388608) ? 24'h800000 : (~dm[23:0] + 24'd1);
      end else begin
         delta_val = (dm > 42'd8388607) ? 24'h7FFFFF : dm[23:0];
      end

      peak_new = (app_max_ff > peak_ff) ? app_max_ff : peak_ff;
   end

   assign q_pop     = (state_ff == S_IDLE) && !q_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         peak_ff      <= '0;
         ch_ff        <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            env_ff[c]  <= '0;
            gain_ff[c] <= ldr_pkg::UNITY_GAIN;
         end
      end else begin
         // S_OUT owns the valid flag in its own cycle
         if (rsp_valid_ff && rsp_ready && (state_ff != S_OUT)) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (!q_empty) begin
                  item_ff    <= q_data;
                  ch_ff      <= 1'b0;
                  app_max_ff <= '0;
                  if (q_data.block_start || q_data.bypass) peak_ff <= '0;
                  if (q_data.bypass) begin
                     for (int c = 0; c < CHANNELS; c++) begin
                        env_ff[c]   <= '0;
                        gain_ff[c]  <= ldr_pkg::UNITY_GAIN;
                        delta_ff[c] <= '0;
                     end
                     state_ff <= S_OUT;
                  end else begin
                     log_x_ff   <= 24'(thr_eff);
                     env_ret_ff <= 1'b0;
                     state_ff   <= S_LOG_START;
                  end
               end
            end
            S_LOG_START: begin
               log_top_ff  <= top;
               log_m_ff    <= m0;
               log_frac_ff <= '0;
               step_ff     <= 4'd15;
               state_ff    <= S_LOG_SQ;
            end
            S_LOG_SQ: begin
               mul_a_ff <= 32'(log_m_ff);
               mul_b_ff <= 32'(log_m_ff);
               state_ff <= S_LOG_UPD;
            end
            S_LOG_UPD: begin
               log_m_ff    <= m_next;
               log_frac_ff <= frac_next;
               if (step_ff == 4'd0) begin
                  if (!env_ret_ff) begin
                     lthr_ff  <= lval;
                     state_ff <= S_CH_START;
                  end else begin
                     mul_a_ff <= 32'(lval - lthr_ff);
                     mul_b_ff <= ldr_pkg::DB_PER_OCTAVE;
                     state_ff <= S_RED_OVER;
                  end
               end else begin
                  step_ff  <= step_ff - 4'd1;
                  state_ff <= S_LOG_SQ;
               end
            end
            S_CH_START: begin
               level_ff <= level_cur;
               up_ff    <= env_cur >= level_cur;
               mul_a_ff <= 32'((level_cur > env_cur) ? cfg.attack_coeff : cfg.release_coeff);
               mul_b_ff <= 32'((env_cur >= level_cur) ? env_cur - level_cur
                                                       : level_cur - env_cur);
               state_ff <= S_ENV_UPD;
            end
            S_ENV_UPD: begin
               for (int c = 0; c < CHANNELS; c++) begin
                  if (item_ff.full_link || ch_ff == 1'(c)) env_ff[c] <= env_new;
               end
               if (env_new > 24'(thr_eff)) begin
                  log_x_ff   <= env_new;
                  env_ret_ff <= 1'b1;
                  state_ff   <= S_LOG_START;
               end else begin
                  applied_ff <= '0;
                  mul_a_ff   <= '0;
                  mul_b_ff   <= ldr_pkg::OCTAVES_PER_DB;
                  state_ff   <= S_GAIN_E;
               end
            end
            S_RED_OVER: begin
               mul_a_ff <= prod[55:24];
               mul_b_ff <= 32'(cfg.reduction_slope);
               state_ff <= S_RED_SLOPE;
            end
            S_RED_SLOPE: begin
               mul_a_ff <= 32'(clamp);
               mul_b_ff <= 32'(item_ff.openness);
               state_ff <= S_RED_OPEN;
            end
            S_RED_OPEN: begin
               applied_ff <= prod[30:16];
               mul_a_ff   <= 32'(prod[30:16]);
               mul_b_ff   <= ldr_pkg::OCTAVES_PER_DB;
               state_ff   <= S_GAIN_E;
            end
            S_GAIN_E: begin
               whole_ff  <= prod[39:24];
               frac_e_ff <= prod[23:8];
               att_ff    <= ldr_pkg::Q30_ONE;
               step_ff   <= 4'd0;
               state_ff  <= S_ATT_MUL;
            end
            S_ATT_MUL: begin
               mul_a_ff <= att_ff;
               mul_b_ff <= frac_e_ff[4'd15 - step_ff] ? ldr_pkg::half_step(step_ff)
                                                       : ldr_pkg::Q30_ONE;
               state_ff <= S_ATT_UPD;
            end
            S_ATT_UPD: begin
               att_ff <= rnd30[61:30];
               if (step_ff == 4'd15) begin
                  state_ff <= S_ATT_SHIFT;
               end else begin
                  step_ff  <= step_ff + 4'd1;
                  state_ff <= S_ATT_MUL;
               end
            end
            S_ATT_SHIFT: begin
               mul_a_ff <= 32'(cfg.static_gain);
               mul_b_ff <= att_s;
               state_ff <= S_TGT;
            end
            S_TGT: begin
               target_ff <= rnd30[53:30];
               if (applied_ff > app_max_ff) app_max_ff <= applied_ff;
               state_ff  <= S_GBLEND;
            end
            S_GBLEND: begin
               up_ff    <= gain_cur >= target_ff;
               mul_a_ff <= 32'(cfg.gain_coeff);
               mul_b_ff <= 32'((gain_cur >= target_ff) ? gain_cur - target_ff
                                                       : target_ff - gain_cur);
               state_ff <= S_GAIN_UPD;
            end
            S_GAIN_UPD: begin
               for (int c = 0; c < CHANNELS; c++) begin
                  if (item_ff.full_link || ch_ff == 1'(c)) gain_ff[c] <= gain_new;
               end
               if (!item_ff.full_link && !ch_ff) begin
                  ch_ff    <= 1'b1;
                  state_ff <= S_CH_START;
               end else begin
                  ch_ff    <= 1'b0;
                  state_ff <= S_DELTA_MUL;
               end
            end
            S_DELTA_MUL: begin
               neg_ff   <= sample_cur[23] ^ gneg;
               mul_a_ff <= 32'(ldr_pkg::abs24(sample_cur));
               mul_b_ff <= 32'(gmag);
               state_ff <= S_DELTA_RES;
            end
            S_DELTA_RES: begin
               for (int c = 0; c < CHANNELS; c++) begin
                  if (ch_ff == 1'(c)) delta_ff[c] <= delta_val;
               end
               if (!ch_ff && (CHANNELS > 1)) begin
                  ch_ff    <= 1'b1;
                  state_ff <= S_DELTA_MUL;
               end else begin
                  ch_ff    <= 1'b0;
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff            <= 1'b1;
                  rsp_data_ff.delta_left  <= delta_ff[0];
                  rsp_data_ff.delta_right <= delta_right_cur;
                  rsp_data_ff.applied_db  <= app_max_ff;
                  rsp_data_ff.peak_db     <= peak_new;
                  peak_ff                 <= peak_new;
                  state_ff                <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== sv/linked_downward_reducer.sv =====
// linked_downward_reducer: top level; register file, front, queue and back.
// Depends on ldr_pkg, ldr_front, ldr_queue, ldr_back.
//
//   port group   dir   handshake              payload
//   req_*        in    req_valid/req_ready    ldr_pkg::req_type
//   rsp_*        out   rsp_valid/rsp_ready    ldr_pkg::rsp_type
//   APB          in    psel/penable/pwrite    paddr[4:2] register, pwdata
//
// Bypass items go from the idle state straight to the output state in the
// back. Other items are sequenced around the one shared 32x32 multiplier,
// shortest with the envelope at or below threshold and full link, longest
// with both channels over threshold and partial link: each log2 is 16
// squarings, each gain 16 exp factors. The front takes an item per cycle,
// while the queue is not full, into a QUEUE_DEPTH-entry queue. Reset is
// synchronous and restores the register file and channel state. A stalled
// result only holds the back in its output state; the queue keeps filling.
module linked_downward_reducer #(
   parameter int CHANNELS    = ldr_pkg::CHANNELS_DEF,
   parameter int QUEUE_DEPTH = ldr_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  ldr_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output ldr_pkg::rsp_type           rsp_data,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [ldr_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   ldr_pkg::cfg_type   cfg_ff;
   ldr_pkg::queue_type push_item, pop_item;
   logic               q_push, q_pop, q_full, q_empty;
   ldr_pkg::reg_index_type reg_sel;

   // register file: written on the access phase, pready tied high
   assign pready  = 1'b1;
   assign reg_sel = ldr_pkg::reg_index_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= ldr_pkg::CFG_RESET;
      end else if (psel && penable && pwrite) begin
         case (reg_sel)
            ldr_pkg::REG_ATTACK:    cfg_ff.attack_coeff     <= pwdata[23:0];
            ldr_pkg::REG_RELEASE:   cfg_ff.release_coeff    <= pwdata[23:0];
            ldr_pkg::REG_GAIN:      cfg_ff.gain_coeff       <= pwdata[23:0];
            ldr_pkg::REG_THRESHOLD: cfg_ff.threshold_level  <= pwdata[22:0];
            ldr_pkg::REG_MAX_DB:    cfg_ff.max_reduction_db <= pwdata[14:0];
            ldr_pkg::REG_STATIC:    cfg_ff.static_gain      <= pwdata[23:0];
            ldr_pkg::REG_LINK:      cfg_ff.stereo_link      <= pwdata[15:0];
            ldr_pkg::REG_SLOPE:     cfg_ff.reduction_slope  <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         ldr_pkg::REG_ATTACK:    prdata = 32'(cfg_ff.attack_coeff);
         ldr_pkg::REG_RELEASE:   prdata = 32'(cfg_ff.release_coeff);
         ldr_pkg::REG_GAIN:      prdata = 32'(cfg_ff.gain_coeff);
         ldr_pkg::REG_THRESHOLD: prdata = 32'(cfg_ff.threshold_level);
         ldr_pkg::REG_MAX_DB:    prdata = 32'(cfg_ff.max_reduction_db);
         ldr_pkg::REG_STATIC:    prdata = 32'(cfg_ff.static_gain);
         ldr_pkg::REG_LINK:      prdata = 32'(cfg_ff.stereo_link);
         ldr_pkg::REG_SLOPE:     prdata = 32'(cfg_ff.reduction_slope);
         default:                prdata = '0;
      endcase
   end

   // front: magnitudes, link blend, bypass and full-link flags
   ldr_front #(.CHANNELS(CHANNELS)) u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (push_item)
   );

   ldr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_item),
      .pop       (q_pop),
      .pop_data  (pop_item),
      .full      (q_full),
      .empty     (q_empty)
   );

   // back: per-item sequencer, owns envelope/gain/peak state and result reg
   ldr_back #(.CHANNELS(CHANNELS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_data    (pop_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sv/ldr_checker.sv =====
// ldr_checker: port-level assertions for linked_downward_reducer, bound in.
// Depends on ldr_pkg (rsp_type).
module ldr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ldr_pkg::rsp_type rsp_data
);

   // a pending result is never dropped
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before accept");

   // a pending result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("result payload changed while waiting");

   // running peak never below this item's reduction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.peak_db >= rsp_data.applied_db)
      else $error("peak below applied reduction");

   // nothing leaves right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // queue is empty after reset, so the input is open
   assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("input closed after reset");

endmodule

bind linked_downward_reducer ldr_checker u_checker (.*);

// ===== dv/linked_downward_reducer_tb.sv =====
// Testbench for linked_downward_reducer: directed and random stereo items,
// several register settings, checked against a built-in bit-exact predictor.
// Depends on ldr_pkg and the linked_downward_reducer RTL.
`timescale 1ns / 1ps

module linked_downward_reducer_tb;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   ldr_pkg::req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   ldr_pkg::rsp_type rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [ldr_pkg::ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   linked_downward_reducer u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor copy of the register file and channel state
   ldr_pkg::cfg_type cfg_shadow;
   logic [31:0] env_st [2];
   logic [31:0] gain_st [2];
   logic [31:0] peak_st;

   ldr_pkg::rsp_type rsp_expected [$];
   int          error_count = 0;
   int          stall_mode = 0;

   // one-pole step, magnitude of the difference times the pole, half up
   function automatic logic [31:0] pole_step(input logic [31:0] tgt,
                                             input logic [31:0] prev,
                                             input logic [31:0] c);
      logic [63:0] d;
      if (prev >= tgt) begin
         d = (64'(c) * 64'(prev - tgt) + 64'd8388608) >> 24;
         return tgt + d[31:0];
      end
      d = (64'(c) * 64'(tgt - prev) + 64'd8388608) >> 24;
      return tgt - d[31:0];
   endfunction

   function automatic logic [31:0] log2_fix(input logic [31:0] x_in);
      logic [31:0] x;
      logic [31:0] top;
      logic [31:0] frac;
      logic [63:0] m;
      x = (x_in == 0) ? 32'd1 : x_in;
      top = 0;
      frac = 0;
      while (top < 31 && (x >> (top + 1)) != 0) top++;
      m = 64'(x) << (30 - top);
      for (int i = 15; i >= 0; i--) begin
         m = (m * m) >> 30;
         if (m >= (64'd2 << 30)) begin
            m = m >> 1;
            frac[i] = 1'b1;
         end
      end
      return (top << 16) | frac;
   endfunction

   function automatic logic [31:0] reduction_db(input logic [31:0] level,
                                                input logic [31:0] openness);
      logic [31:0] thr;
      logic [63:0] diff;
      logic [63:0] over;
      logic [63:0] scaled;
      thr = (cfg_shadow.threshold_level == 0) ? 32'd1 : 32'(cfg_shadow.threshold_level);
      if (level <= thr) return 0;
      diff = 64'(log2_fix(level) - log2_fix(thr));
      over = (diff * 64'(ldr_pkg::DB_PER_OCTAVE)) >> 24;
      scaled = (over * 64'(cfg_shadow.reduction_slope)) >> 16;
      if (scaled > 64'(cfg_shadow.max_reduction_db))
         scaled = 64'(cfg_shadow.max_reduction_db);
      return 32'((scaled * 64'(openness)) >> 16);
   endfunction

   // reduction in dB to linear gain through 2^-octaves times static gain
   function automatic logic [31:0] gain_for(input logic [31:0] applied);
      logic [31:0] e;
      logic [31:0] whole;
      logic [63:0] att;
      logic [63:0] g;
      static logic [31:0] steps [16] = '{
         759250125, 902905651, 984625594, 1028218693, 1050733751, 1062175491,
         1067942999, 1070838486, 1072289173, 1073015253, 1073378477,
         1073560135, 1073650976, 1073696399, 1073719111, 1073730468};
      if (applied == 0) return 32'(cfg_shadow.static_gain);
      e = 32'((64'(applied) * 64'(ldr_pkg::OCTAVES_PER_DB)) >> 8);
      whole = e >> 16;
      att = 64'(ldr_pkg::Q30_ONE);
      for (int i = 0; i < 16; i++)
         if (e[15 - i]) att = (att * 64'(steps[i]) + 64'd536870912) >> 30;
      att = (whole >= 31) ? 64'd0 : (att >> whole);
      g = (64'(cfg_shadow.static_gain) * att + 64'd536870912) >> 30;
      return g[31:0];
   endfunction

   function automatic logic [31:0] channel_step(input int ch, input logic [31:0] level,
                                                input logic [31:0] openness);
      logic [31:0] c;
      logic [31:0] applied;
      c = (level > env_st[ch]) ? 32'(cfg_shadow.attack_coeff) : 32'(cfg_shadow.release_coeff);
      env_st[ch] = pole_step(level, env_st[ch], c);
      applied = reduction_db(env_st[ch], openness);
      gain_st[ch] = pole_step(gain_for(applied), gain_st[ch], 32'(cfg_shadow.gain_coeff));
      return applied;
   endfunction

   function automatic logic [23:0] delta_for(input logic signed [23:0] s,
                                             input logic [31:0] g);
      logic signed [63:0] p;
      logic [63:0] m;
      p = 64'(s) * (64'(g) - 64'(ldr_pkg::UNITY_GAIN));
      m = (p < 0) ? 64'(-p) : 64'(p);
      m = (m + 64'd2097152) >> 22;
      if (p < 0) return (m > 64'd8388608) ? 24'h800000 : 24'(-m);
      return (m > 64'd8388607) ? 24'h7FFFFF : 24'(m);
   endfunction

   function automatic ldr_pkg::rsp_type predict_reduction(input ldr_pkg::req_type it);
      ldr_pkg::rsp_type r;
      logic [31:0] openness;
      logic [31:0] mag_l;
      logic [31:0] mag_r;
      logic [31:0] loud;
      logic [31:0] det_l;
      logic [31:0] det_r;
      logic [31:0] applied;
      logic [31:0] a1;
      logic [63:0] t;
      openness = 32'd65536 - 32'(it.gate_amount);
      mag_l = 32'(ldr_pkg::abs24(it.sample_left));
      mag_r = 32'(ldr_pkg::abs24(it.sample_right));
      if (it.block_start) peak_st = 0;
      r = '0;
      if (cfg_shadow.max_reduction_db == 0 &&
          cfg_shadow.static_gain == ldr_pkg::UNITY_GAIN) begin
         env_st = '{0, 0};
         gain_st = '{ldr_pkg::UNITY_GAIN, ldr_pkg::UNITY_GAIN};
         peak_st = 0;
         return r;
      end
      loud = (mag_r > mag_l) ? mag_r : mag_l;
      if (cfg_shadow.stereo_link >= ldr_pkg::FULL_LINK) begin
         applied = channel_step(0, loud, openness);
         env_st[1] = env_st[0];
         gain_st[1] = gain_st[0];
      end else begin
         t = (64'(cfg_shadow.stereo_link) * 64'(loud - mag_l) + 64'd32768) >> 16;
         det_l = mag_l + t[31:0];
         t = (64'(cfg_shadow.stereo_link) * 64'(loud - mag_r) + 64'd32768) >> 16;
         det_r = mag_r + t[31:0];
         applied = channel_step(0, det_l, openness);
         a1 = channel_step(1, det_r, openness);
         if (a1 > applied) applied = a1;
      end
      if (applied > peak_st) peak_st = applied;
      r.delta_left = delta_for(it.sample_left, gain_st[0]);
      r.delta_right = delta_for(it.sample_right, gain_st[1]);
      r.applied_db = applied[14:0];
      r.peak_db = peak_st[14:0];
      return r;
   endfunction

   // receiver: stall pattern changes per phase; compares each accepted item
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         if (rsp_expected.size() == 0) begin
            $error("unexpected result item");
            error_count++;
         end else begin
            ldr_pkg::rsp_type e;
            e = rsp_expected.pop_front();
            if (rsp_data.delta_left !== e.delta_left) begin
               $error("delta_left exp %0d got %0d", e.delta_left, rsp_data.delta_left);
               error_count++;
            end
            if (rsp_data.delta_right !== e.delta_right) begin
               $error("delta_right exp %0d got %0d", e.delta_right, rsp_data.delta_right);
               error_count++;
            end
            if (rsp_data.applied_db !== e.applied_db) begin
               $error("applied_db exp %0d got %0d", e.applied_db, rsp_data.applied_db);
               error_count++;
            end
            if (rsp_data.peak_db !== e.peak_db) begin
               $error("peak_db exp %0d got %0d", e.peak_db, rsp_data.peak_db);
               error_count++;
            end
         end
      end
      case (stall_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= ($urandom_range(3, 0) != 0);
         default: rsp_ready <= ($urandom_range(9, 0) < 3);
      endcase
   end

   int burst_left = 0;

   // send one item; bursts with random gaps between them
   task automatic send_item(input ldr_pkg::req_type it);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(12, 1);
         gap = $urandom_range(40, 0);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      rsp_expected.push_back(predict_reduction(it));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (rsp_expected.size() != 0) @(posedge clock);
      repeat (250) @(posedge clock);
   endtask

   task automatic write_reg(input ldr_pkg::reg_index_type idx, input logic [31:0] v);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ldr_pkg::ADDR_W'(idx) << 2;
      pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         ldr_pkg::REG_ATTACK:    cfg_shadow.attack_coeff = v[23:0];
         ldr_pkg::REG_RELEASE:   cfg_shadow.release_coeff = v[23:0];
         ldr_pkg::REG_GAIN:      cfg_shadow.gain_coeff = v[23:0];
         ldr_pkg::REG_THRESHOLD: cfg_shadow.threshold_level = v[22:0];
         ldr_pkg::REG_MAX_DB:    cfg_shadow.max_reduction_db = v[14:0];
         ldr_pkg::REG_STATIC:    cfg_shadow.static_gain = v[23:0];
         ldr_pkg::REG_LINK:      cfg_shadow.stereo_link = v[15:0];
         default:                cfg_shadow.reduction_slope = v[15:0];
      endcase
   endtask

   function automatic ldr_pkg::req_type rand_item();
      ldr_pkg::req_type it;
      it.sample_left = 24'($urandom);
      it.sample_right = 24'($urandom);
      it.gate_amount = ($urandom_range(3, 0) == 0) ? 16'($urandom) : 16'd0;
      it.block_start = ($urandom_range(15, 0) == 0);
      return it;
   endfunction

   function automatic ldr_pkg::req_type mk(input int l, input int r, input int g,
                                           input bit b);
      ldr_pkg::req_type it;
      it.sample_left = 24'(l);
      it.sample_right = 24'(r);
      it.gate_amount = 16'(g);
      it.block_start = b;
      return it;
   endfunction

   task automatic test_bypass();
      send_item(mk(8388607, -8388608, 0, 1'b0));
      send_item(mk(-8388608, 8388607, 65535, 1'b1));
      send_item(rand_item());
      drain_results();
   endtask

   // compression active, full link; extremes of every input field
   task automatic test_directed();
      write_reg(ldr_pkg::REG_MAX_DB, 24576);
      write_reg(ldr_pkg::REG_SLOPE, 65535);
      write_reg(ldr_pkg::REG_ATTACK, 0);
      send_item(mk(8388607, 8388607, 0, 1'b1));
      send_item(mk(-8388608, -8388608, 0, 1'b0));
      send_item(mk(0, 0, 65535, 1'b0));
      send_item(mk(8388607, 0, 65535, 1'b0));
      send_item(mk(-8388608, 1, 32768, 1'b1));
      send_item(mk(100, -100, 0, 1'b0));
      // sender holds off until the block is empty
      drain_results();
      write_reg(ldr_pkg::REG_THRESHOLD, 0);   // zero threshold acts as one
      send_item(mk(2, -3, 0, 1'b0));
      send_item(mk(8388607, -8388608, 0, 1'b0));
      drain_results();
      write_reg(ldr_pkg::REG_THRESHOLD, 8388607);
      send_item(mk(8388607, 100, 0, 1'b1));
      drain_results();
   endtask

   task automatic random_phase(input int n, input int mode);
      stall_mode = mode;
      for (int i = 0; i < n; i++) send_item(rand_item());
      drain_results();
   endtask

   // several register settings, partial link, extremes and random values
   task automatic test_random();
      write_reg(ldr_pkg::REG_THRESHOLD, 838861);
      write_reg(ldr_pkg::REG_ATTACK, 16609443);
      write_reg(ldr_pkg::REG_LINK, 0);
      write_reg(ldr_pkg::REG_GAIN, 0);
      random_phase(180, 1);
      write_reg(ldr_pkg::REG_LINK, 32768);
      write_reg(ldr_pkg::REG_GAIN, 16777215);
      write_reg(ldr_pkg::REG_RELEASE, 0);
      write_reg(ldr_pkg::REG_STATIC, 16777215);
      write_reg(ldr_pkg::REG_MAX_DB, 32767);   // ceiling above range used as written
      random_phase(180, 2);
      write_reg(ldr_pkg::REG_LINK, 65469);
      write_reg(ldr_pkg::REG_RELEASE, 16777215);
      write_reg(ldr_pkg::REG_STATIC, 0);
      write_reg(ldr_pkg::REG_MAX_DB, 0);
      write_reg(ldr_pkg::REG_SLOPE, 0);
      random_phase(180, 0);
      for (int k = 0; k < 3; k++) begin
         write_reg(ldr_pkg::REG_ATTACK, $urandom_range(16777215, 0));
         write_reg(ldr_pkg::REG_RELEASE, $urandom_range(16777215, 0));
         write_reg(ldr_pkg::REG_GAIN, $urandom_range(16777215, 16000000));
         write_reg(ldr_pkg::REG_THRESHOLD, $urandom_range(8388607, 1));
         write_reg(ldr_pkg::REG_MAX_DB, $urandom_range(24576, 1));
         write_reg(ldr_pkg::REG_STATIC, $urandom_range(16777215, 0));
         write_reg(ldr_pkg::REG_LINK, $urandom_range(65535, 0));
         write_reg(ldr_pkg::REG_SLOPE, $urandom_range(65535, 0));
         random_phase(180, k % 3);
      end
   endtask

   initial begin
      cfg_shadow = ldr_pkg::CFG_RESET;
      env_st = '{0, 0};
      gain_st = '{ldr_pkg::UNITY_GAIN, ldr_pkg::UNITY_GAIN};
      peak_st = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_bypass();
      test_directed();
      test_random();
      if (error_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   // roughly 1100 items plus stalls and gaps
   initial begin
      #4000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
